// ===== rtl/core/arp_pkg.sv =====
`timescale 1ns / 1ps

package arp_pkg;

   // Request operation codes.
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // One table entry as it is held in memory.
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] ttl;
   } entry_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/arp_entry_ram.sv =====
`timescale 1ns / 1ps

module arp_entry_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  arp_pkg::entry_type    wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output arp_pkg::entry_type    rd_data
);

   arp_pkg::entry_type mem [DEPTH];
   arp_pkg::entry_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/arp_cache_table_core.sv =====
`timescale 1ns / 1ps

// Add, the unused code, and find or delete on an empty table go straight to done;
// find and delete otherwise first scan the stored entries with one memory read per cycle
// and, for delete, one entry moved down per cycle. The response loads from done once the
// output register is free. One request is worked on at a time, and the next is taken once
// the sequencer is back in idle; a waiting response holds back only the next response.
// Reset (synchronous, active high) empties the table; entry contents are not cleared.
module arp_cache_table_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_ip_address,
   input  logic [47:0] req_mac_address,
   input  logic [15:0] req_time_to_live,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_found_mac,
   output logic [15:0] rsp_found_ttl
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   arp_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      hole_ff, hole_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [31:0]        ip_ff, ip_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [47:0]        res_mac_ff, res_mac_in;
   logic [15:0]        res_ttl_ff, res_ttl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [47:0]        rsp_mac_ff, rsp_mac_in;
   logic [15:0]        rsp_ttl_ff, rsp_ttl_in;

   logic               accept;
   logic               is_lookup;
   logic               match;
   logic               slot_free;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   arp_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   arp_pkg::entry_type rd_data;

   arp_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshake and compare terms used by the combinational blocks.
   assign req_stall = (state_ff != arp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_lookup = (req_command == arp_pkg::CMD_FIND) ||
                      (req_command == arp_pkg::CMD_DELETE);
   assign match     = chk_valid_ff && (rd_data.ip == ip_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (is_lookup && (count_ff != '0)) begin
                  state_in = arp_pkg::ST_SCAN;
               end else begin
                  state_in = arp_pkg::ST_DONE;
               end
            end
         end
         arp_pkg::ST_SCAN: begin
            if (!chk_valid_ff) begin
               state_in = arp_pkg::ST_DONE;
            end else if (match) begin
               if (cmd_ff == arp_pkg::CMD_DELETE) begin
                  state_in = arp_pkg::ST_SHIFT;
               end else begin
                  state_in = arp_pkg::ST_DONE;
               end
            end
         end
         arp_pkg::ST_SHIFT: begin
            if (!chk_valid_ff) begin
               state_in = arp_pkg::ST_DONE;
            end
         end
         arp_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = arp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arp_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory control, scan pointers and result capture.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      hole_in       = hole_ff;
      chk_valid_in  = 1'b0;
      cmd_in        = cmd_ff;
      ip_in         = ip_ff;
      res_status_in = res_status_ff;
      res_mac_in    = res_mac_ff;
      res_ttl_in    = res_ttl_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = '{ip: req_ip_address, mac: req_mac_address, ttl: req_time_to_live};
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         arp_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_command;
               ip_in         = req_ip_address;
               res_status_in = arp_pkg::STATUS_NOT_FOUND;
               res_mac_in    = '0;
               res_ttl_in    = '0;
               unique case (req_command) inside
                  arp_pkg::CMD_ADD: begin
                     if (count_ff == DEPTH_C) begin
                        res_status_in = arp_pkg::STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + 1'b1;
                        res_status_in = arp_pkg::STATUS_OK;
                     end
                  end
                  arp_pkg::CMD_DELETE, arp_pkg::CMD_FIND: begin
                     // The first entry is read right away.
                     if (count_ff != '0) begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        idx_in       = CW'(1);
                        chk_valid_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         arp_pkg::ST_SCAN, arp_pkg::ST_SHIFT: begin
            // One read is issued per cycle while entries remain.
            if (idx_ff < count_ff) begin
               rd_en        = 1'b1;
               idx_in       = idx_ff + 1'b1;
               chk_valid_in = 1'b1;
            end
            if (state_ff == arp_pkg::ST_SCAN) begin
               if (match) begin
                  res_status_in = arp_pkg::STATUS_OK;
                  hole_in       = AW'(idx_ff - 1'b1);
                  if (cmd_ff == arp_pkg::CMD_FIND) begin
                     res_mac_in = rd_data.mac;
                     res_ttl_in = rd_data.ttl;
                  end
               end
            end else begin
               // Move the entry after the gap down into it.
               if (chk_valid_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = rd_data;
                  hole_in = hole_ff + 1'b1;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         arp_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Output register loads when the finished request's response can be placed.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_ttl_in    = rsp_ttl_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if ((state_ff == arp_pkg::ST_DONE) && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_mac_in    = res_mac_ff;
         rsp_ttl_in    = res_ttl_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arp_pkg::ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hole_ff       <= hole_in;
      cmd_ff        <= cmd_in;
      ip_ff         <= ip_in;
      res_status_ff <= res_status_in;
      res_mac_ff    <= res_mac_in;
      res_ttl_ff    <= res_ttl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
      rsp_ttl_ff    <= rsp_ttl_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_mac = rsp_mac_ff;
   assign rsp_found_ttl = rsp_ttl_ff;

endmodule
